/* rtl/mt19937_random_generator_assert.svh */
// Assertion helpers; clocked on clk and held off while rst_n is low.
`ifndef MT19937_RANDOM_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define MTRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mtrg_pkg.sv */
package mtrg_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned N_WORDS  = 624;
  localparam int unsigned SHIFT    = 397;
  localparam int unsigned FAR_WRAP = N_WORDS - SHIFT;
  localparam int unsigned AW       = $clog2(N_WORDS + 1);

  // Configuration port
  localparam int unsigned CFG_AW   = 3;
  localparam logic        REG_SEED = 1'b0;

  localparam int unsigned OUT_FIFO_DEPTH = 4;

  localparam logic [WORD_W-1:0] MATRIX    = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] INIT_MULT = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C  = 32'hEFC6_0000;
  localparam logic [WORD_W-1:0] UPPER     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER     = 32'h7FFF_FFFF;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [AW-1:0]     addr_t;

  typedef struct packed {
    word_t             random_word;
    logic [BYTE_W-1:0] device_byte;
    logic              last;
  } result_t;

  // Output tempering
  function automatic word_t temper(input word_t y_in);
    word_t y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Residue mod 255: 256 folds to 1, so sum the bytes, fold once and subtract 255 if still at or above it
  function automatic logic [BYTE_W-1:0] mod255(input word_t w);
    logic [9:0] s1;
    logic [8:0] s2;
    s1 = {2'b00, w[7:0]} + {2'b00, w[15:8]} + {2'b00, w[23:16]} + {2'b00, w[31:24]};
    s2 = {7'd0, s1[9:8]} + {1'b0, s1[7:0]};
    if (s2 >= 9'd255) begin
      return 8'(s2 - 9'd255);
    end
    return s2[7:0];
  endfunction

endpackage

/* rtl/mtrg_if.sv */
// Request channel
interface mtrg_in_if;
  logic valid;
  logic ready;
  logic last_of_read;

  modport source (output valid, output last_of_read, input ready);
  modport sink   (input valid, input last_of_read, output ready);
endinterface

// Result channel
interface mtrg_out_if;
  logic                              valid;
  logic                              ready;
  logic [mtrg_pkg::WORD_W-1:0]       random_word;
  logic [mtrg_pkg::BYTE_W-1:0]       device_byte;
  logic                              last;

  modport source (output valid, output random_word, output device_byte, output last,
                  input ready);
  modport sink   (input valid, input random_word, input device_byte, input last,
                  output ready);
endinterface

/* rtl/mtrg_out_fifo.sv */
module mtrg_out_fifo #(
  parameter int unsigned DEPTH = mtrg_pkg::OUT_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_i,
  input  mtrg_pkg::result_t          push_data_i,
  input  logic                       pop_i,
  output mtrg_pkg::result_t          head_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mtrg_pkg::result_t store_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;

  // Store item
  always_ff @(posedge clk) begin
    if (push_i) begin
      store_r[wr_ptr_r] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head_o  = store_r[rd_ptr_r];
  assign count_o = count_r;

endmodule

/* rtl/mt19937_random_generator.sv */
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   last_of_read
// out_ch    out  valid/ready   random_word, device_byte, last
// APB       in   psel/penable  seed register at byte address 0
//
// One item per cycle sustained while ready is high; each item passes from accept to
// the output queue through address issue, state read/twist/write-back and tempering.
// Throughput is set by the state memory: two read ports and one write port.
// After reset and after each seed write, a fill pass rebuilds all 624 words of the
// state memory; no item is accepted during it.
// Output stalls are absorbed by the output queue; besides a fill pass, ready drops
// only once it and the in-flight items would exceed its depth.
`include "mt19937_random_generator_assert.svh"

module mt19937_random_generator #(
  parameter int unsigned FIFO_DEPTH = mtrg_pkg::OUT_FIFO_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mtrg_in_if.sink                       in_ch,
  mtrg_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtrg_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned AW = mtrg_pkg::AW;

  // State memory
  mtrg_pkg::word_t state_mem [mtrg_pkg::N_WORDS];

  mtrg_pkg::word_t seed_val_r;

  logic            fill_active_r;
  logic [AW-1:0]   fill_idx_r;
  mtrg_pkg::word_t fill_word_r;
  mtrg_pkg::word_t fill_mix;
  mtrg_pkg::word_t fill_word_nxt;
  logic [AW-1:0]   fill_idx_nxt;
  logic            fill_last;

  logic [AW-1:0]   pos_r;
  logic [AW-1:0]   draw_addr;
  logic [AW-1:0]   nxt_addr;
  logic [AW-1:0]   far_addr;
  mtrg_pkg::word_t cur_r;

  mtrg_pkg::word_t rd_nxt_q;
  mtrg_pkg::word_t rd_far_q;

  logic            b_valid_r;
  logic [AW-1:0]   b_addr_r;
  logic            b_last_r;
  mtrg_pkg::word_t twist_y;
  mtrg_pkg::word_t twist_ya;
  mtrg_pkg::word_t twist_word;

  logic            c_valid_r;
  mtrg_pkg::word_t c_word_r;
  logic            c_last_r;
  mtrg_pkg::word_t tempered;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  mtrg_pkg::word_t mem_wdata;

  logic            cfg_wr;
  logic            seed_wr;
  logic            in_accept;
  logic            out_pop;
  logic [CW-1:0]   fifo_count;
  logic [CW:0]     occupancy;

  mtrg_pkg::result_t push_data;
  mtrg_pkg::result_t head;

  // Configuration write decode and read data
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign seed_wr = cfg_wr && (paddr[2] == mtrg_pkg::REG_SEED);
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == mtrg_pkg::REG_SEED) ? seed_val_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_val_r <= '0;
    end else if (seed_wr) begin
      seed_val_r <= pwdata;
    end
  end

  // Fill recurrence: next word from the current one and the next index
  assign fill_mix      = fill_word_r ^ (fill_word_r >> 30);
  assign fill_idx_nxt  = fill_idx_r + 1'b1;
  assign fill_word_nxt = mtrg_pkg::INIT_MULT * fill_mix
                       + {{(mtrg_pkg::WORD_W - AW){1'b0}}, fill_idx_nxt};
  assign fill_last     = fill_active_r && (fill_idx_r == AW'(mtrg_pkg::N_WORDS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_active_r <= 1'b1;
      fill_idx_r    <= '0;
      fill_word_r   <= '0;
    end else if (seed_wr) begin
      fill_active_r <= 1'b1;
      fill_idx_r    <= '0;
      fill_word_r   <= pwdata;
    end else if (fill_active_r) begin
      fill_idx_r  <= fill_idx_nxt;
      fill_word_r <= fill_word_nxt;
      if (fill_idx_r == AW'(mtrg_pkg::N_WORDS - 1)) begin
        fill_active_r <= 1'b0;
      end
    end
  end

  // Draw address and its two read partners
  assign draw_addr = (pos_r >= AW'(mtrg_pkg::N_WORDS)) ? '0 : pos_r;
  assign nxt_addr  = (draw_addr == AW'(mtrg_pkg::N_WORDS - 1)) ? '0 : draw_addr + 1'b1;
  assign far_addr  = (draw_addr < AW'(mtrg_pkg::FAR_WRAP))
                   ? draw_addr + AW'(mtrg_pkg::SHIFT)
                   : draw_addr - AW'(mtrg_pkg::FAR_WRAP);

  // Accept outside a fill pass while the queue has room for everything in flight
  assign occupancy   = {1'b0, fifo_count} + {{CW{1'b0}}, b_valid_r}
                     + {{CW{1'b0}}, c_valid_r};
  assign in_ch.ready = !fill_active_r && (occupancy < (CW+1)'(FIFO_DEPTH));
  assign in_accept   = in_ch.valid && in_ch.ready;

  // Twist one entry from held current word and the two reads
  assign twist_y    = (cur_r & mtrg_pkg::UPPER) | (rd_nxt_q & mtrg_pkg::LOWER);
  assign twist_ya   = (twist_y >> 1) ^ (twist_y[0] ? mtrg_pkg::MATRIX : '0);
  assign twist_word = rd_far_q ^ twist_ya;

  // Write port: fill pass or twist write-back
  assign mem_we    = fill_active_r || b_valid_r;
  assign mem_waddr = fill_active_r ? fill_idx_r : b_addr_r;
  assign mem_wdata = fill_active_r ? fill_word_r : twist_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      state_mem[mem_waddr] <= mem_wdata;
    end
    rd_nxt_q <= state_mem[nxt_addr];
    rd_far_q <= state_mem[far_addr];
  end

  // Position and the held untwisted word at the draw position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= AW'(mtrg_pkg::N_WORDS);
      cur_r <= '0;
    end else if (seed_wr) begin
      pos_r <= AW'(mtrg_pkg::N_WORDS);
      cur_r <= pwdata;
    end else begin
      if (in_accept) begin
        pos_r <= draw_addr + 1'b1;
      end
      if (b_valid_r) begin
        cur_r <= rd_nxt_q;
      end
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      b_valid_r <= in_accept;
      c_valid_r <= b_valid_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    b_addr_r <= draw_addr;
    b_last_r <= in_ch.last_of_read;
    c_word_r <= twist_word;
    c_last_r <= b_last_r;
  end

  // Temper and reduce, then queue the item
  assign tempered              = mtrg_pkg::temper(c_word_r);
  assign push_data.random_word = tempered;
  assign push_data.device_byte = mtrg_pkg::mod255(tempered);
  assign push_data.last        = c_last_r;

  assign out_pop = out_ch.valid && out_ch.ready;

  mtrg_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (c_valid_r),
    .push_data_i (push_data),
    .pop_i       (out_pop),
    .head_o      (head),
    .count_o     (fifo_count)
  );

  assign out_ch.valid       = (fifo_count != '0);
  assign out_ch.random_word = head.random_word;
  assign out_ch.device_byte = head.device_byte;
  assign out_ch.last        = head.last;

  `MTRG_ASSERT_NOW(a_no_accept_in_fill, fill_active_r, !in_accept, "item accepted during fill")
  `MTRG_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= AW'(mtrg_pkg::N_WORDS), "draw position overflow")
  `MTRG_ASSERT_NOW(a_queue_credit, 1'b1, occupancy <= (CW+1)'(FIFO_DEPTH), "queue overcommitted")
  `MTRG_ASSERT_NEXT(a_fill_done_pos, fill_last && !seed_wr, !fill_active_r && (pos_r == AW'(mtrg_pkg::N_WORDS)), "fill end without round restart")

endmodule

/* tb/sv/mt19937_random_generator_checker.sv */
module mt19937_random_generator_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  mtrg_in_if                          in_ch,
  mtrg_out_if                         out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mtrg_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          mismatch_count,
  output int                          draws_outstanding
);

  localparam int unsigned     MT_N          = 624;
  localparam int unsigned     MT_M          = 397;
  localparam mtrg_pkg::word_t TWIST_XOR     = 32'h9908_B0DF;
  localparam mtrg_pkg::word_t SEED_MULT     = 32'd1812433253;
  localparam mtrg_pkg::word_t TEMPER_MASK_B = 32'h9D2C_5680;
  localparam mtrg_pkg::word_t TEMPER_MASK_C = 32'hEFC6_0000;
  localparam int unsigned     BYTE_MOD      = 255;
  localparam int              MAX_REPORTS   = 10;

  // Shadow of the generator: state store, draw position and seed register
  mtrg_pkg::word_t   mt_state [MT_N];
  logic [9:0]        draw_pos;
  mtrg_pkg::word_t   seed_reg;
  mtrg_pkg::result_t queued_draws [$];
  int                failures;

  // Rebuild the whole state store from a seed and restart the draw position
  function automatic void reseed(input mtrg_pkg::word_t s);
    mtrg_pkg::word_t w;
    mt_state[0] = s;
    for (int k = 1; k < MT_N; k++) begin
      w = mt_state[k-1];
      mt_state[k] = SEED_MULT * (w ^ (w >> 30)) + mtrg_pkg::word_t'(k);
    end
    draw_pos = 10'(MT_N);
  endfunction

  function automatic mtrg_pkg::word_t mt_temper(input mtrg_pkg::word_t v);
    mtrg_pkg::word_t t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TEMPER_MASK_B);
    t = t ^ ((t << 15) & TEMPER_MASK_C);
    return t ^ (t >> 18);
  endfunction

  // Twist one entry, temper it and queue the expected draw
  function automatic void twist_and_temper(input logic last_of_read);
    int unsigned       p;
    int unsigned       nxt;
    int unsigned       far_idx;
    mtrg_pkg::word_t   mixed;
    mtrg_pkg::word_t   y;
    mtrg_pkg::result_t r;
    p = (draw_pos >= MT_N) ? 0 : int'(draw_pos);
    nxt = (p + 1) % MT_N;
    far_idx = (p + MT_M) % MT_N;
    mixed = {mt_state[p][31], mt_state[nxt][30:0]};
    mixed = (mixed >> 1) ^ (mixed[0] ? TWIST_XOR : '0);
    mt_state[p] = mt_state[far_idx] ^ mixed;
    y = mt_temper(mt_state[p]);
    draw_pos = 10'(p + 1);
    r.random_word = y;
    r.device_byte = 8'(y % BYTE_MOD);
    r.last = last_of_read;
    queued_draws.push_back(r);
  endfunction

  function automatic void report_failure(input string what);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%s", what);
    end
  endfunction

  // Compare one accepted result against the oldest prediction
  function automatic void check_draw(input mtrg_pkg::result_t got);
    mtrg_pkg::result_t want;
    if (queued_draws.size() == 0) begin
      report_failure($sformatf("unexpected draw: word %h byte %0d last %b",
                               got.random_word, got.device_byte, got.last));
      return;
    end
    want = queued_draws.pop_front();
    if (got.random_word !== want.random_word || got.device_byte !== want.device_byte ||
        got.last !== want.last) begin
      report_failure($sformatf(
        "draw mismatch: expected word %h byte %0d last %b, got word %h byte %0d last %b",
        want.random_word, want.device_byte, want.last,
        got.random_word, got.device_byte, got.last));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      // Hold the shadow at its reset state
      seed_reg = '0;
      reseed('0);
      queued_draws.delete();
      failures = 0;
    end else begin
      // Follow register writes and check reads of the seed
      if (psel && penable && pready &&
          paddr[mtrg_pkg::CFG_AW-1:2] == mtrg_pkg::REG_SEED) begin
        if (pwrite) begin
          seed_reg = pwdata;
          reseed(pwdata);
        end else if (prdata !== seed_reg) begin
          report_failure($sformatf("seed read mismatch: expected %h, got %h",
                                   seed_reg, prdata));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        twist_and_temper(in_ch.last_of_read);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_draw('{random_word: out_ch.random_word, device_byte: out_ch.device_byte,
                     last: out_ch.last});
      end
    end
    mismatch_count <= failures;
    draws_outstanding <= queued_draws.size();
  end

endmodule

/* tb/sv/mt19937_random_generator_test.sv */
module mt19937_random_generator_test;

  localparam logic [mtrg_pkg::CFG_AW-1:0] SEED_ADDR =
    (mtrg_pkg::CFG_AW)'(mtrg_pkg::REG_SEED) << 2;
  localparam logic [mtrg_pkg::CFG_AW-1:0] UNUSED_ADDR =
    (mtrg_pkg::CFG_AW)'(!mtrg_pkg::REG_SEED) << 2;
  localparam int         MAX_WAIT       = 13;
  localparam int         HOLD_AFTER     = 200;
  localparam int         LONG_HOLD      = 300;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         OPENING_LEN    = 14;
  localparam bit [13:0]  OPENING_LASTS  = 14'b00010110010011;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [mtrg_pkg::CFG_AW-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  int                          mismatch_count;
  int                          draws_outstanding;
  int                          quiet_cycles;

  mtrg_in_if  in_ch ();
  mtrg_out_if out_ch ();

  mt19937_random_generator u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mt19937_random_generator_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .mismatch_count    (mismatch_count),
    .draws_outstanding (draws_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one byte request after an optional gap and hold it until taken
  task automatic offer_request(input logic last_of_read, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.last_of_read <= last_of_read;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stream device reads of random length, with some stray flags mixed in
  task automatic draw_phase(input int count);
    int   left;
    bit   burst;
    logic lor;
    left = 0;
    burst = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      if (left == 0) begin
        left = $urandom_range(1, 16);
      end
      lor = (left == 1);
      left--;
      if ($urandom_range(0, 9) == 0) begin
        lor = 1'($urandom_range(0, 1));
      end
      offer_request(lor, burst);
    end
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every predicted draw has come out
  task automatic drain();
    @(posedge clk);
    while (draws_outstanding != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [mtrg_pkg::CFG_AW-1:0] addr,
                            input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stimulus
  initial begin
    mtrg_pkg::word_t phase_seed [6];
    int              phase_len [6];
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.last_of_read <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Draw from the reset state; seed reads back as zero
    cfg_access(1'b0, SEED_ADDR, '0);
    for (int i = OPENING_LEN - 1; i >= 0; i--) begin
      offer_request(OPENING_LASTS[i], i > 7);
    end
    in_ch.valid <= 1'b0;
    drain();

    // A write to an unmapped register leaves the sequence running
    cfg_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) begin
      offer_request(i[0], 1'b0);
    end
    in_ch.valid <= 1'b0;
    drain();

    // All-ones seed written mid-round
    cfg_access(1'b1, SEED_ADDR, 32'hFFFF_FFFF);
    cfg_access(1'b0, SEED_ADDR, '0);
    for (int i = 0; i < 4; i++) begin
      offer_request(i == 3, 1'b1);
    end
    in_ch.valid <= 1'b0;

    // Random phases, each under a new seed; the first runs past a full round
    phase_seed[0] = '0;
    phase_seed[1] = 32'd5489;
    phase_seed[2] = $urandom;
    phase_seed[3] = 32'h8000_0000;
    phase_seed[4] = $urandom;
    phase_seed[5] = 32'hFFFF_FFFF;
    phase_len[0] = 700;
    phase_len[1] = 120;
    phase_len[2] = 150;
    phase_len[3] = 100;
    phase_len[4] = 90;
    phase_len[5] = 90;
    for (int p = 0; p < 6; p++) begin
      drain();
      cfg_access(1'b1, SEED_ADDR, phase_seed[p]);
      cfg_access(1'b0, SEED_ADDR, '0);
      draw_phase(phase_len[p]);
    end

    // Let the last results out, then settle
    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && draws_outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold to back the block up
  initial begin
    int  stall;
    int  taken;
    bit  burst;
    taken = 0;
    burst = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken % 40 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      if (taken == HOLD_AFTER) begin
        stall = LONG_HOLD;
      end else begin
        stall = burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      taken++;
    end
  end

  // Watchdog: give up after a long run with no transfer of any kind
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                 (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
                 (psel && penable && pready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
